// ===== hdl/olm_pkg.sv =====
// ----------------------------------------------------------------------------
// olm_pkg
// Shared types and constants of the overlap luminance error block: register
// indexes and reset values, datapath widths, step limits and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package olm_pkg;

  localparam int unsigned CH_W   = 8;   // color channel width
  localparam int unsigned DIF_W  = 9;   // signed channel difference
  localparam int unsigned PP_W   = 11;  // sum of three selected differences
  localparam int unsigned WGT_W  = 16;  // luminance weight, Q0.16
  localparam int unsigned LUM_W  = 27;  // signed weighted luminance, Q.16
  localparam int unsigned MAG_W  = 16;  // luminance magnitude, Q8.8
  localparam int unsigned SQ_W   = 32;  // squared magnitude, Q16.16
  localparam int unsigned SUM_W  = 48;  // error sum
  localparam int unsigned OUT_W  = 32;  // mse result, Q16.16
  localparam int unsigned CFG_W  = 16;  // configuration data
  localparam int unsigned IDX_W  = 3;   // configuration index
  localparam int unsigned STEP_W = 6;   // step counter, holds SUM_W - 1

  localparam logic [IDX_W-1:0] REG_TILE_W  = 3'd0;
  localparam logic [IDX_W-1:0] REG_TILE_H  = 3'd1;
  localparam logic [IDX_W-1:0] REG_SEAM_W  = 3'd2;
  localparam logic [IDX_W-1:0] REG_SEAM_H  = 3'd3;
  localparam logic [IDX_W-1:0] REG_WGT_R   = 3'd4;
  localparam logic [IDX_W-1:0] REG_WGT_G   = 3'd5;
  localparam logic [IDX_W-1:0] REG_WGT_B   = 3'd6;

  localparam logic [CH_W-1:0]  RST_TILE    = 8'd32;
  localparam logic [CH_W-1:0]  RST_SEAM    = 8'd6;
  localparam logic [WGT_W-1:0] RST_WGT_R   = 16'd19595;
  localparam logic [WGT_W-1:0] RST_WGT_G   = 16'd38470;
  localparam logic [WGT_W-1:0] RST_WGT_B   = 16'd7471;

  localparam logic [STEP_W-1:0] LUM_LAST   = 6'(WGT_W - 1);
  localparam logic [STEP_W-1:0] SQR_LAST   = 6'(MAG_W - 1);
  localparam logic [STEP_W-1:0] DIV_LAST   = 6'(SUM_W - 1);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_LUM  = 7'b0000010,
    ST_MAG  = 7'b0000100,
    ST_SQR  = 7'b0001000,
    ST_ACC  = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_HOLD = 7'b1000000
  } state_e;

endpackage

`default_nettype wire

// ===== hdl/overlap_luma_mse.sv =====
// ----------------------------------------------------------------------------
// overlap_luma_mse
// Mean squared luminance error over the overlap band of one candidate tile.
// ----------------------------------------------------------------------------
// Pixel pairs arrive in raster order; the block tracks column and row itself
// and emits one mse transfer after the last pixel of each tile. A pixel
// outside the overlap goes from idle straight to accumulation. A pixel in the
// overlap passes through the bit-serial weighted luminance (one weight bit per
// cycle), rounding, the bit-serial square and accumulation. The last pixel of
// a tile adds restoring division (one quotient bit per cycle) and the load of
// the output register, which waits while an earlier result is stalled.
// The output register lets the next tile start while a result waits. A write
// to any defined register restarts the current tile.
// ----------------------------------------------------------------------------
`default_nettype none

module overlap_luma_mse #(
  parameter int unsigned MAX_TILE_DIM = 128
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [olm_pkg::IDX_W-1:0] cfg_idx_i,
  input  wire logic [olm_pkg::CFG_W-1:0] cfg_data_i,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [olm_pkg::CH_W-1:0]  src_red_i,
  input  wire logic [olm_pkg::CH_W-1:0]  src_green_i,
  input  wire logic [olm_pkg::CH_W-1:0]  src_blue_i,
  input  wire logic [olm_pkg::CH_W-1:0]  tgt_red_i,
  input  wire logic [olm_pkg::CH_W-1:0]  tgt_green_i,
  input  wire logic [olm_pkg::CH_W-1:0]  tgt_blue_i,
  input  wire logic                      left_overlap_i,
  input  wire logic                      top_overlap_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [olm_pkg::OUT_W-1:0]      mse_o
);

  localparam int unsigned CNT_W = $clog2(MAX_TILE_DIM);
  localparam int unsigned DIM_W = $clog2(MAX_TILE_DIM + 1);
  localparam int unsigned EXT_W = (DIM_W > olm_pkg::CH_W) ? DIM_W : olm_pkg::CH_W;
  localparam int unsigned OVL_W = $clog2(MAX_TILE_DIM * MAX_TILE_DIM + 1);
  localparam logic [EXT_W-1:0] MAX_DIM = EXT_W'(MAX_TILE_DIM);
  localparam logic [EXT_W-1:0] ONE_DIM = EXT_W'(1);

  // configuration
  logic [olm_pkg::CH_W-1:0]  tile_w_q, tile_h_q, seam_w_q, seam_h_q;
  logic [olm_pkg::WGT_W-1:0] wgt_r_q, wgt_g_q, wgt_b_q;
  logic                      cfg_hit;

  // control
  olm_pkg::state_e           state_q, state_d;
  logic [olm_pkg::STEP_W-1:0] step_q, step_d;
  logic [CNT_W-1:0]          col_q, col_d, row_q, row_d;
  logic [OVL_W-1:0]          ovl_q, ovl_d;
  logic [olm_pkg::SUM_W-1:0] sum_q, sum_d;
  logic                      out_valid_q, out_valid_d;
  logic                      keep_q, keep_d;
  logic                      zero_q, zero_d;

  // datapath
  logic signed [olm_pkg::DIF_W-1:0] dr_q, dg_q, db_q, dr_d, dg_d, db_d;
  logic [olm_pkg::WGT_W-1:0] wsr_r_q, wsr_g_q, wsr_b_q, wsr_r_d, wsr_g_d, wsr_b_d;
  logic signed [olm_pkg::LUM_W-1:0] lum_q, lum_d;
  logic [olm_pkg::MAG_W-1:0] mag_q, mag_d, mplr_q, mplr_d;
  logic [olm_pkg::SQ_W-1:0]  sq_q, sq_d;
  logic [olm_pkg::SUM_W-1:0] dq_q, dq_d;
  logic [OVL_W-1:0]          div_q, div_d, rem_q, rem_d;
  logic [olm_pkg::OUT_W-1:0] out_q, out_d;

  // effective dimensions
  logic [EXT_W-1:0] tw, th, sw, sh, tw_raw, th_raw, sw_raw, sh_raw;
  logic [EXT_W-1:0] col_next, row_next;
  logic             keep_in, in_acc, out_free, tile_end;

  logic signed [olm_pkg::PP_W-1:0]  part;
  logic [olm_pkg::LUM_W-1:0]        mag_sel, mag_rnd;
  logic [olm_pkg::SUM_W:0]          sum_add;
  logic [olm_pkg::SUM_W-1:0]        sum_new;
  logic [OVL_W-1:0]                 ovl_new;
  logic [OVL_W:0]                   rem_try;
  logic                             rem_ge;

  always_comb begin
    tw_raw = EXT_W'(tile_w_q);
    th_raw = EXT_W'(tile_h_q);
    sw_raw = EXT_W'(seam_w_q);
    sh_raw = EXT_W'(seam_h_q);
    tw = (tw_raw == '0) ? ONE_DIM : ((tw_raw > MAX_DIM) ? MAX_DIM : tw_raw);
    th = (th_raw == '0) ? ONE_DIM : ((th_raw > MAX_DIM) ? MAX_DIM : th_raw);
    sw = (sw_raw == '0) ? ONE_DIM : ((sw_raw > tw) ? tw : sw_raw);
    sh = (sh_raw == '0) ? ONE_DIM : ((sh_raw > th) ? th : sh_raw);
  end

  assign keep_in  = (left_overlap_i && (EXT_W'(col_q) < sw)) ||
                    (top_overlap_i && (EXT_W'(row_q) < sh));
  assign in_stall_o = (state_q != olm_pkg::ST_IDLE);
  assign in_acc   = in_valid_i && (state_q == olm_pkg::ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign col_next = EXT_W'(col_q) + ONE_DIM;
  assign row_next = EXT_W'(row_q) + ONE_DIM;
  assign tile_end = (col_next >= tw) && (row_next >= th);

  assign cfg_hit = cfg_we_i &&
                   (cfg_idx_i inside {olm_pkg::REG_TILE_W, olm_pkg::REG_TILE_H,
                                      olm_pkg::REG_SEAM_W, olm_pkg::REG_SEAM_H,
                                      olm_pkg::REG_WGT_R, olm_pkg::REG_WGT_G,
                                      olm_pkg::REG_WGT_B});

  // one weight bit per cycle, msb first
  always_comb begin
    part = '0;
    if (wsr_r_q[olm_pkg::WGT_W-1]) part = part + olm_pkg::PP_W'(dr_q);
    if (wsr_g_q[olm_pkg::WGT_W-1]) part = part + olm_pkg::PP_W'(dg_q);
    if (wsr_b_q[olm_pkg::WGT_W-1]) part = part + olm_pkg::PP_W'(db_q);
  end

  // round half up on the magnitude
  assign mag_sel = lum_q[olm_pkg::LUM_W-1] ? ~lum_q : lum_q;
  assign mag_rnd = mag_sel + (lum_q[olm_pkg::LUM_W-1] ? olm_pkg::LUM_W'(129)
                                                      : olm_pkg::LUM_W'(128));

  assign sum_add = {1'b0, sum_q} + {{(olm_pkg::SUM_W-olm_pkg::SQ_W+1){1'b0}}, sq_q};
  assign sum_new = !keep_q ? sum_q :
                   (sum_add[olm_pkg::SUM_W] ? {olm_pkg::SUM_W{1'b1}}
                                            : sum_add[olm_pkg::SUM_W-1:0]);
  assign ovl_new = keep_q ? ovl_q + OVL_W'(1) : ovl_q;

  assign rem_try = {rem_q, dq_q[olm_pkg::SUM_W-1]};
  assign rem_ge  = (rem_try >= {1'b0, div_q});

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    col_d       = col_q;
    row_d       = row_q;
    ovl_d       = ovl_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q && out_stall_i;
    keep_d      = keep_q;
    zero_d      = zero_q;
    dr_d        = dr_q;
    dg_d        = dg_q;
    db_d        = db_q;
    wsr_r_d     = wsr_r_q;
    wsr_g_d     = wsr_g_q;
    wsr_b_d     = wsr_b_q;
    lum_d       = lum_q;
    mag_d       = mag_q;
    mplr_d      = mplr_q;
    sq_d        = sq_q;
    dq_d        = dq_q;
    div_d       = div_q;
    rem_d       = rem_q;
    out_d       = out_q;

    case (state_q)
      olm_pkg::ST_IDLE: begin
        if (in_acc) begin
          keep_d  = keep_in;
          dr_d    = $signed({1'b0, src_red_i}) - $signed({1'b0, tgt_red_i});
          dg_d    = $signed({1'b0, src_green_i}) - $signed({1'b0, tgt_green_i});
          db_d    = $signed({1'b0, src_blue_i}) - $signed({1'b0, tgt_blue_i});
          wsr_r_d = wgt_r_q;
          wsr_g_d = wgt_g_q;
          wsr_b_d = wgt_b_q;
          lum_d   = '0;
          step_d  = '0;
          state_d = keep_in ? olm_pkg::ST_LUM : olm_pkg::ST_ACC;
        end
      end
      olm_pkg::ST_LUM: begin
        lum_d   = (lum_q <<< 1) + olm_pkg::LUM_W'(part);
        wsr_r_d = wsr_r_q << 1;
        wsr_g_d = wsr_g_q << 1;
        wsr_b_d = wsr_b_q << 1;
        step_d  = step_q + 1'b1;
        if (step_q == olm_pkg::LUM_LAST) begin
          state_d = olm_pkg::ST_MAG;
        end
      end
      olm_pkg::ST_MAG: begin
        if (mag_rnd[olm_pkg::LUM_W-1:olm_pkg::MAG_W+8] != '0) begin
          mag_d = {olm_pkg::MAG_W{1'b1}};
        end else begin
          mag_d = mag_rnd[olm_pkg::MAG_W+7:8];
        end
        mplr_d  = mag_d;
        sq_d    = '0;
        step_d  = '0;
        state_d = olm_pkg::ST_SQR;
      end
      olm_pkg::ST_SQR: begin
        sq_d   = (sq_q << 1) +
                 (mplr_q[olm_pkg::MAG_W-1] ? olm_pkg::SQ_W'(mag_q) : '0);
        mplr_d = mplr_q << 1;
        step_d = step_q + 1'b1;
        if (step_q == olm_pkg::SQR_LAST) begin
          state_d = olm_pkg::ST_ACC;
        end
      end
      olm_pkg::ST_ACC: begin
        if (tile_end) begin
          dq_d    = sum_new;
          div_d   = ovl_new;
          zero_d  = (ovl_new == '0);
          rem_d   = '0;
          step_d  = '0;
          sum_d   = '0;
          ovl_d   = '0;
          col_d   = '0;
          row_d   = '0;
          state_d = olm_pkg::ST_DIV;
        end else begin
          sum_d = sum_new;
          ovl_d = ovl_new;
          if (col_next >= tw) begin
            col_d = '0;
            row_d = row_q + 1'b1;
          end else begin
            col_d = col_q + 1'b1;
          end
          state_d = olm_pkg::ST_IDLE;
        end
      end
      olm_pkg::ST_DIV: begin
        rem_d  = rem_ge ? OVL_W'(rem_try - {1'b0, div_q}) : rem_try[OVL_W-1:0];
        dq_d   = {dq_q[olm_pkg::SUM_W-2:0], rem_ge};
        step_d = step_q + 1'b1;
        if (step_q == olm_pkg::DIV_LAST) begin
          state_d = olm_pkg::ST_HOLD;
        end
      end
      olm_pkg::ST_HOLD: begin
        if (out_free) begin
          if (zero_q) begin
            out_d = '0;
          end else if (dq_q[olm_pkg::SUM_W-1:olm_pkg::OUT_W] != '0) begin
            out_d = {olm_pkg::OUT_W{1'b1}};
          end else begin
            out_d = dq_q[olm_pkg::OUT_W-1:0];
          end
          out_valid_d = 1'b1;
          state_d     = olm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = olm_pkg::ST_IDLE;
      end
    endcase

    // a register write restarts the tile
    if (cfg_hit) begin
      sum_d = '0;
      ovl_d = '0;
      col_d = '0;
      row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_w_q <= olm_pkg::RST_TILE;
      tile_h_q <= olm_pkg::RST_TILE;
      seam_w_q <= olm_pkg::RST_SEAM;
      seam_h_q <= olm_pkg::RST_SEAM;
      wgt_r_q  <= olm_pkg::RST_WGT_R;
      wgt_g_q  <= olm_pkg::RST_WGT_G;
      wgt_b_q  <= olm_pkg::RST_WGT_B;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        olm_pkg::REG_TILE_W: tile_w_q <= cfg_data_i[olm_pkg::CH_W-1:0];
        olm_pkg::REG_TILE_H: tile_h_q <= cfg_data_i[olm_pkg::CH_W-1:0];
        olm_pkg::REG_SEAM_W: seam_w_q <= cfg_data_i[olm_pkg::CH_W-1:0];
        olm_pkg::REG_SEAM_H: seam_h_q <= cfg_data_i[olm_pkg::CH_W-1:0];
        olm_pkg::REG_WGT_R:  wgt_r_q  <= cfg_data_i;
        olm_pkg::REG_WGT_G:  wgt_g_q  <= cfg_data_i;
        olm_pkg::REG_WGT_B:  wgt_b_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= olm_pkg::ST_IDLE;
      step_q      <= '0;
      col_q       <= '0;
      row_q       <= '0;
      ovl_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
      keep_q      <= 1'b0;
      zero_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      col_q       <= col_d;
      row_q       <= row_d;
      ovl_q       <= ovl_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
      keep_q      <= keep_d;
      zero_q      <= zero_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dr_q    <= dr_d;
    dg_q    <= dg_d;
    db_q    <= db_d;
    wsr_r_q <= wsr_r_d;
    wsr_g_q <= wsr_g_d;
    wsr_b_q <= wsr_b_d;
    lum_q   <= lum_d;
    mag_q   <= mag_d;
    mplr_q  <= mplr_d;
    sq_q    <= sq_d;
    dq_q    <= dq_d;
    div_q   <= div_d;
    rem_q   <= rem_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign mse_o       = out_q;

endmodule

`default_nettype wire

// ===== sim/overlap_luma_mse_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overlap_luma_mse_test
// Streams candidate tiles of source/target pixel pairs through the overlap
// luminance error block under random valid and stall gaps. Tile geometry,
// seams and luminance weights change between phases. Each mse transfer is
// compared with a bit-exact software calculation of the overlap error.
// ----------------------------------------------------------------------------

module overlap_luma_mse_test;

  localparam int unsigned                    TILE_MAX     = 128;
  localparam int                             DRAIN_CYCLES = 120;
  localparam int                             ITEM_TARGET  = 1250;
  localparam logic [olm_pkg::IDX_W-1:0]      REG_NONE     = 3'd7;
  localparam longint unsigned                SUM_MAX      =
    (64'd1 << olm_pkg::SUM_W) - 64'd1;

  typedef struct packed {
    logic [olm_pkg::CH_W-1:0] src_r;
    logic [olm_pkg::CH_W-1:0] src_g;
    logic [olm_pkg::CH_W-1:0] src_b;
    logic [olm_pkg::CH_W-1:0] tgt_r;
    logic [olm_pkg::CH_W-1:0] tgt_g;
    logic [olm_pkg::CH_W-1:0] tgt_b;
    logic                     left;
    logic                     top;
  } pixel_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [olm_pkg::IDX_W-1:0] cfg_idx_i;
  logic [olm_pkg::CFG_W-1:0] cfg_data_i;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [olm_pkg::CH_W-1:0]  src_red_i;
  logic [olm_pkg::CH_W-1:0]  src_green_i;
  logic [olm_pkg::CH_W-1:0]  src_blue_i;
  logic [olm_pkg::CH_W-1:0]  tgt_red_i;
  logic [olm_pkg::CH_W-1:0]  tgt_green_i;
  logic [olm_pkg::CH_W-1:0]  tgt_blue_i;
  logic                      left_overlap_i;
  logic                      top_overlap_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic [olm_pkg::OUT_W-1:0] mse_o;

  bit calm;
  int sent;
  int stall_left;

  class overlap_mse_calc;
    logic [olm_pkg::CH_W-1:0]  tile_w, tile_h, seam_w, seam_h;
    logic [olm_pkg::WGT_W-1:0] wgt_r, wgt_g, wgt_b;
    longint unsigned           err_sum;
    int unsigned               col, row, kept;
    logic [olm_pkg::OUT_W-1:0] mse_due_q[$];
    int unsigned               failures;

    function new();
      tile_w   = olm_pkg::RST_TILE;
      tile_h   = olm_pkg::RST_TILE;
      seam_w   = olm_pkg::RST_SEAM;
      seam_h   = olm_pkg::RST_SEAM;
      wgt_r    = olm_pkg::RST_WGT_R;
      wgt_g    = olm_pkg::RST_WGT_G;
      wgt_b    = olm_pkg::RST_WGT_B;
      failures = 0;
      restart();
    endfunction

    function void restart();
      err_sum = 0;
      col     = 0;
      row     = 0;
      kept    = 0;
    endfunction

    function int unsigned eff_dim(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
    endfunction

    function int pending();
      return mse_due_q.size();
    endfunction

    function bit at_tile_start();
      return (col == 0) && (row == 0);
    endfunction

    function void write_reg(logic [olm_pkg::IDX_W-1:0] idx,
                            logic [olm_pkg::CFG_W-1:0] data);
      case (idx)
        olm_pkg::REG_TILE_W: tile_w = data[olm_pkg::CH_W-1:0];
        olm_pkg::REG_TILE_H: tile_h = data[olm_pkg::CH_W-1:0];
        olm_pkg::REG_SEAM_W: seam_w = data[olm_pkg::CH_W-1:0];
        olm_pkg::REG_SEAM_H: seam_h = data[olm_pkg::CH_W-1:0];
        olm_pkg::REG_WGT_R:  wgt_r  = data;
        olm_pkg::REG_WGT_G:  wgt_g  = data;
        olm_pkg::REG_WGT_B:  wgt_b  = data;
        default:             return;
      endcase
      restart();
    endfunction

    function void note_pixel(pixel_t p);
      int unsigned     tw, th, sw, sh;
      longint          lum, mag, m;
      longint unsigned sq, q;
      tw = eff_dim(tile_w, TILE_MAX);
      th = eff_dim(tile_h, TILE_MAX);
      sw = eff_dim(seam_w, tw);
      sh = eff_dim(seam_h, th);
      if ((p.left && col < sw) || (p.top && row < sh)) begin
        lum = longint'(wgt_r) * (longint'(p.src_r) - longint'(p.tgt_r))
            + longint'(wgt_g) * (longint'(p.src_g) - longint'(p.tgt_g))
            + longint'(wgt_b) * (longint'(p.src_b) - longint'(p.tgt_b));
        mag = (lum < 0) ? -lum : lum;
        m = (mag + 128) >> 8;
        if (m > 65535) m = 65535;
        sq = longint'(m * m);
        err_sum = (err_sum > SUM_MAX - sq) ? SUM_MAX : err_sum + sq;
        kept++;
      end
      col++;
      if (col >= tw) begin
        col = 0;
        row++;
        if (row >= th) begin
          q = 0;
          if (kept != 0) q = err_sum / longint'(kept);
          if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
          mse_due_q.push_back(q[olm_pkg::OUT_W-1:0]);
          restart();
        end
      end
    endfunction

    function void check_mse(logic [olm_pkg::OUT_W-1:0] got);
      logic [olm_pkg::OUT_W-1:0] want;
      if (mse_due_q.size() == 0) begin
        $display("%0t: unexpected mse transfer, expected none actual %h", $time, got);
        failures++;
        return;
      end
      want = mse_due_q.pop_front();
      if (got !== want) begin
        $display("%0t: mse mismatch, expected %h actual %h", $time, want, got);
        failures++;
      end
    endfunction
  endclass

  overlap_mse_calc model;

  overlap_luma_mse #(
    .MAX_TILE_DIM(TILE_MAX)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .src_red_i      (src_red_i),
    .src_green_i    (src_green_i),
    .src_blue_i     (src_blue_i),
    .tgt_red_i      (tgt_red_i),
    .tgt_green_i    (tgt_green_i),
    .tgt_blue_i     (tgt_blue_i),
    .left_overlap_i (left_overlap_i),
    .top_overlap_i  (top_overlap_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .mse_o          (mse_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // mostly short gaps, a few long ones, none in calm phases
  function automatic int gap_len();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic next_stall();
    if (stall_left > 0) begin
      stall_left--;
      return 1'b1;
    end
    stall_left = gap_len();
    return 1'b0;
  endfunction

  initial begin
    stall_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) model.check_mse(mse_o);
      out_stall_i <= next_stall();
    end
  end

  function automatic pixel_t make_pixel(input logic [olm_pkg::CH_W-1:0] sr, sg, sb,
                                        input logic [olm_pkg::CH_W-1:0] tr, tg, tb,
                                        input bit left, top);
    pixel_t p;
    p = '{src_r: sr, src_g: sg, src_b: sb, tgt_r: tr, tgt_g: tg, tgt_b: tb,
          left: left, top: top};
    return p;
  endfunction

  function automatic pixel_t rand_pixel(input bit left, input bit top);
    logic [olm_pkg::CH_W-1:0] src_c [3];
    logic [olm_pkg::CH_W-1:0] tgt_c [3];
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(0, 9))
        0: begin
          src_c[i] = 8'($urandom);
          tgt_c[i] = src_c[i];
        end
        1: begin
          src_c[i] = 8'hFF;
          tgt_c[i] = 8'h00;
        end
        2: begin
          src_c[i] = 8'h00;
          tgt_c[i] = 8'hFF;
        end
        default: begin
          src_c[i] = 8'($urandom);
          tgt_c[i] = 8'($urandom);
        end
      endcase
    end
    return make_pixel(src_c[0], src_c[1], src_c[2], tgt_c[0], tgt_c[1], tgt_c[2],
                      left, top);
  endfunction

  task automatic send_pixel(input pixel_t p);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    src_red_i      <= p.src_r;
    src_green_i    <= p.src_g;
    src_blue_i     <= p.src_b;
    tgt_red_i      <= p.tgt_r;
    tgt_green_i    <= p.tgt_g;
    tgt_blue_i     <= p.tgt_b;
    left_overlap_i <= p.left;
    top_overlap_i  <= p.top;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    model.note_pixel(p);
    sent++;
  endtask

  // pixels up to the end of the current tile
  task automatic send_tile(input bit left, input bit top, input int unsigned noise_pct);
    bit l, t;
    do begin
      l = left;
      t = top;
      if ($urandom_range(0, 99) < noise_pct) begin
        l = $urandom_range(0, 1);
        t = $urandom_range(0, 1);
      end
      send_pixel(rand_pixel(l, t));
    end while (!model.at_tile_start());
  endtask

  task automatic write_reg(input logic [olm_pkg::IDX_W-1:0] idx,
                           input logic [olm_pkg::CFG_W-1:0] data);
    in_valid_i <= 1'b0;
    while (model.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    model.write_reg(idx, data);
  endtask

  function automatic logic [olm_pkg::CH_W-1:0] seam_value(input int unsigned dim);
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'hFF;
      2:       return 8'(dim + $urandom_range(1, 3));
      default: return 8'($urandom_range(1, (dim == 0) ? 1 : dim));
    endcase
  endfunction

  function automatic logic [olm_pkg::WGT_W-1:0] rand_weight();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_config();
    int unsigned w, h;
    w = $urandom_range(1, 8);
    h = $urandom_range(1, 8);
    case ($urandom_range(0, 19))
      0: w = 0;
      1: begin
        w = $urandom_range(129, 255);
        h = 1;
      end
      2: begin
        w = 1;
        h = $urandom_range(128, 255);
      end
      3: h = 0;
      default: ;
    endcase
    write_reg(olm_pkg::REG_TILE_W, {8'($urandom), 8'(w)});
    write_reg(olm_pkg::REG_TILE_H, {8'($urandom), 8'(h)});
    if ($urandom_range(0, 1))
      write_reg(olm_pkg::REG_SEAM_W, {8'($urandom), seam_value(w)});
    if ($urandom_range(0, 1))
      write_reg(olm_pkg::REG_SEAM_H, {8'($urandom), seam_value(h)});
    if ($urandom_range(0, 2) == 0) write_reg(olm_pkg::REG_WGT_R, rand_weight());
    if ($urandom_range(0, 2) == 0) write_reg(olm_pkg::REG_WGT_G, rand_weight());
    if ($urandom_range(0, 2) == 0) write_reg(olm_pkg::REG_WGT_B, rand_weight());
    if ($urandom_range(0, 7) == 0) write_reg(REG_NONE, 16'($urandom));
  endtask

  initial begin
    bit l, t;
    model          = new();
    calm           = 1'b0;
    sent           = 0;
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= '0;
    cfg_data_i     <= '0;
    in_valid_i     <= 1'b0;
    src_red_i      <= '0;
    src_green_i    <= '0;
    src_blue_i     <= '0;
    tgt_red_i      <= '0;
    tgt_green_i    <= '0;
    tgt_blue_i     <= '0;
    left_overlap_i <= 1'b0;
    top_overlap_i  <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset width, seam width and weights on a single row
    write_reg(olm_pkg::REG_TILE_H, 16'd1);
    send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0));
    send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0));
    send_tile(1'b1, 1'b0, 0);

    // reset seam height, upper data byte ignored
    write_reg(olm_pkg::REG_TILE_W, 16'hC301);
    write_reg(olm_pkg::REG_TILE_H, 16'd8);
    send_tile(1'b0, 1'b1, 0);

    // full-scale weights saturate the magnitude, zero seams count as one
    write_reg(olm_pkg::REG_WGT_R, 16'hFFFF);
    write_reg(olm_pkg::REG_WGT_G, 16'hFFFF);
    write_reg(olm_pkg::REG_WGT_B, 16'hFFFF);
    write_reg(olm_pkg::REG_TILE_W, 16'hA502);
    write_reg(olm_pkg::REG_TILE_H, 16'd2);
    write_reg(olm_pkg::REG_SEAM_W, 16'h0100);
    write_reg(olm_pkg::REG_SEAM_H, 16'h0000);
    send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1));
    send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1));
    send_pixel(make_pixel(8'h80, 8'h00, 8'hFF, 8'h7F, 8'hFF, 8'h00, 1'b1, 1'b0));
    send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1));

    // rounding around half an lsb, both signs
    write_reg(olm_pkg::REG_WGT_R, 16'd128);
    write_reg(olm_pkg::REG_WGT_G, 16'd127);
    write_reg(olm_pkg::REG_WGT_B, 16'd0);
    write_reg(olm_pkg::REG_TILE_W, 16'd3);
    write_reg(olm_pkg::REG_TILE_H, 16'd1);
    send_pixel(make_pixel(8'd1, 8'd0, 8'd9, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1));
    send_pixel(make_pixel(8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1));
    send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd0, 1'b0, 1'b1));

    // no overlap gives zero
    send_tile(1'b0, 1'b0, 0);

    // ignored index keeps the tile, a real write restarts it
    write_reg(olm_pkg::REG_TILE_H, 16'd3);
    repeat (4) send_pixel(rand_pixel(1'b1, 1'b1));
    write_reg(REG_NONE, 16'hFFFF);
    send_tile(1'b1, 1'b1, 0);
    repeat (2) send_pixel(rand_pixel(1'b1, 1'b0));
    write_reg(olm_pkg::REG_SEAM_W, 16'd2);
    send_tile(1'b1, 1'b0, 0);

    while (sent < ITEM_TARGET) begin
      calm = ($urandom_range(0, 4) == 0);
      random_config();
      repeat ($urandom_range(1, 5)) begin
        l = $urandom_range(0, 1);
        t = $urandom_range(0, 1);
        send_tile(l, t, 10);
      end
      // leave a partial tile for the next configuration write to drop
      if ($urandom_range(0, 5) == 0)
        repeat ($urandom_range(1, 3)) send_pixel(rand_pixel(1'b1, 1'b1));
    end

    in_valid_i <= 1'b0;
    while (model.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (model.failures == 0 && model.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/olm_pkg.sv
hdl/overlap_luma_mse.sv
sim/overlap_luma_mse_test.sv
